@@ sv/deq_pkg.sv @@
// Shared widths, operation codes and status codes for the double-ended queue.
// No dependencies; every other file imports this package.
package deq_pkg;

  localparam int FUNC_W        = 3;
  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 7;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ sv/deq_if.sv @@
// Valid/ready channel interfaces for the queue's request and result words.
// Depends on deq_pkg for the payload widths.
interface deq_in_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] item;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;
  logic                     last;

  modport source (output valid, item, status, occupancy, last, input ready);
  modport sink (input valid, item, status, occupancy, last, output ready);
endinterface

@@ sv/deq_ram.sv @@
// Entry storage: one write port, one read port with registered read data.
// Depends on deq_pkg for the data width.
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/double_ended_queue.sv @@
// Bounded double-ended queue over a ring buffer held in deq_ram.
// Depends on deq_pkg, deq_in_if, deq_out_if and deq_ram.
//
//   channel  dir  payload                           words per request
//   req      in   func, value                       1
//   rsp      out  item, status, occupancy, last     1, or one per entry on dump
//
// Push and any empty/full result: written straight to the output register.
// Pop: the memory read first, then the result is loaded into the output register.
// Dump: the read port streams one entry per cycle while rsp is not stalled.
// Reset clears state, head, count and rsp.valid only; storage is never read before it is written.
// A stalled rsp holds the output word and the sequencer; req waits until idle and the output is free.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DATA = 1'b1;

  logic              state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [OCC_W-1:0]  count, count_next;
  logic [OCC_W-1:0]  idx, idx_next;
  logic              dump, dump_next;

  logic              out_free, out_load;
  logic [DATA_W-1:0] item_next;
  logic [STATUS_W-1:0] status_next;
  logic [OCC_W-1:0]  occ_next;
  logic              last_next;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr, head_dec;
  logic [DATA_W-1:0] rdata;
  logic              full, empty, dump_last;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [OCC_W-1:0] off);
    logic [OCC_W:0] sum;
    sum = {{(OCC_W+1-AW){1'b0}}, base} + {1'b0, off};
    if (sum >= {1'b0, DEPTH_C}) begin
      sum = sum - {1'b0, DEPTH_C};
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count >= DEPTH_C);
  assign empty     = (count == '0);
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign dump_last = (idx + OCC_W'(1)) == count;

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    dump_next   = dump;
    out_load    = 1'b0;
    item_next   = '0;
    status_next = ST_OK;
    occ_next    = count;
    last_next   = 1'b1;
    we          = 1'b0;
    waddr       = head;
    re          = 1'b0;
    raddr       = head;

    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          unique case (req.func)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + OCC_W'(1);
                occ_next   = count_next;
                if (req.func == FN_PUSH_BACK) begin
                  waddr = slot(head, count);
                end else begin
                  waddr     = head_dec;
                  head_next = head_dec;
                end
              end
            end
            FN_DUMP, FN_POP_FRONT, FN_POP_BACK: begin
              if (empty) begin
                out_load    = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                re         = 1'b1;
                state_next = S_DATA;
                idx_next   = '0;
                dump_next  = (req.func == FN_DUMP);
                if (req.func == FN_POP_FRONT) begin
                  head_next  = slot(head, OCC_W'(1));
                  count_next = count - OCC_W'(1);
                end else if (req.func == FN_POP_BACK) begin
                  raddr      = slot(head, count - OCC_W'(1));
                  count_next = count - OCC_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_load  = 1'b1;
          item_next = rdata;
          last_next = dump ? dump_last : 1'b1;
          if (last_next) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + OCC_W'(1);
            re       = 1'b1;
            raddr    = slot(head, idx_next);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    dump <= dump_next;
    if (out_load) begin
      rsp.item      <= item_next;
      rsp.status    <= status_next;
      rsp.occupancy <= occ_next;
      rsp.last      <= last_next;
    end
  end

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
